// File: design/mkv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkv_pkg: shared types and constants of the multimap key/value table
// Opcodes, result status codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package mkv_pkg;

   // fixed widths of the opcode, status and emitted key/value fields
   localparam int OPCODE_WIDTH = 2;
   localparam int STATUS_WIDTH = 2;
   localparam int OUT_WIDTH    = 32;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_INSERT = 2'd0,
      OP_FIND   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_DUMP   = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK     = 2'd0,
      ST_ABSENT = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FLUSH
   } state_type;

endpackage

// File: design/mkv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkv_if: request and response channels of the multimap key/value table
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------

// request channel: one operation per transfer
interface mkv_req_if
   import mkv_pkg::*;
#(
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) ();
   logic                    valid;
   logic                    ready;
   logic [OPCODE_WIDTH-1:0] opcode;
   logic [KEY_WIDTH-1:0]    key;
   logic [VALUE_WIDTH-1:0]  value;

   modport source (output valid, output opcode, output key, output value, input ready);
   modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

// response channel: one or more results per request
interface mkv_rsp_if
   import mkv_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [STATUS_WIDTH-1:0] status;
   logic [OUT_WIDTH-1:0]    entry_key;
   logic [OUT_WIDTH-1:0]    entry_value;
   logic                    last;

   modport source (output valid, output status, output entry_key, output entry_value,
                   output last, input ready);
   modport sink   (input valid, input status, input entry_key, input entry_value,
                   input last, output ready);
endinterface

// File: design/mkv_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkv_store: pair storage of the multimap key/value table
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module mkv_store
   import mkv_pkg::*;
#(
   parameter int DEPTH       = 32,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [KEY_WIDTH-1:0]       wr_key,
   input  logic [VALUE_WIDTH-1:0]     wr_value,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [KEY_WIDTH-1:0]       rd_key,
   output logic [VALUE_WIDTH-1:0]     rd_value
);

   localparam int EntryWidth = KEY_WIDTH + VALUE_WIDTH;

   logic [EntryWidth-1:0] store_ff [DEPTH];
   logic [EntryWidth-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= {wr_key, wr_value};
      end
   end

   // read port; data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_key   = rd_data_ff[EntryWidth-1:VALUE_WIDTH];
   assign rd_value = rd_data_ff[VALUE_WIDTH-1:0];

endmodule

// File: design/mkv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkv_ctrl: sequencer of the multimap key/value table
// Walks the store one entry a cycle, unless stalled, through a single key
// comparator, holds the latest match back one step so the final result can
// carry last, compacts the table on remove and drives the registered response.
// ----------------------------------------------------------------------------
module mkv_ctrl
   import mkv_pkg::*;
#(
   parameter int DEPTH       = 32,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   mkv_req_if.sink                    req,
   mkv_rsp_if.source                  rsp,
   output logic                       mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]   mem_wr_addr,
   output logic [KEY_WIDTH-1:0]       mem_wr_key,
   output logic [VALUE_WIDTH-1:0]     mem_wr_value,
   output logic                       mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]   mem_rd_addr,
   input  logic [KEY_WIDTH-1:0]       mem_rd_key,
   input  logic [VALUE_WIDTH-1:0]     mem_rd_value
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]            wr_ptr_ff, wr_ptr_in;
   opcode_type               op_ff, op_in;
   logic [KEY_WIDTH-1:0]     key_ff, key_in;
   logic                     data_vld_ff, data_vld_in;
   logic                     pend_vld_ff, pend_vld_in;
   logic [KEY_WIDTH-1:0]     pend_key_ff, pend_key_in;
   logic [VALUE_WIDTH-1:0]   pend_value_ff, pend_value_in;
   logic                     out_vld_ff, out_vld_in;
   status_type               out_status_ff, out_status_in;
   logic [OUT_WIDTH-1:0]     out_key_ff, out_key_in;
   logic [OUT_WIDTH-1:0]     out_value_ff, out_value_in;
   logic                     out_last_ff, out_last_in;

   opcode_type               req_op;
   logic                     out_free;
   logic                     req_xfer;
   logic                     table_full;
   logic                     table_empty;
   logic                     key_hit;
   logic                     hit;
   logic                     stall;
   logic                     scan_done;

   // zero-extend or truncate keys and values to the response width
   logic [KEY_WIDTH+OUT_WIDTH-1:0]   req_key_ext, pend_key_ext;
   logic [VALUE_WIDTH+OUT_WIDTH-1:0] req_value_ext, pend_value_ext;

   assign req_key_ext    = {{OUT_WIDTH{1'b0}}, req.key};
   assign pend_key_ext   = {{OUT_WIDTH{1'b0}}, pend_key_ff};
   assign req_value_ext  = {{OUT_WIDTH{1'b0}}, req.value};
   assign pend_value_ext = {{OUT_WIDTH{1'b0}}, pend_value_ff};

   // handshake and status terms
   assign req_op      = opcode_type'(req.opcode);
   assign out_free    = !out_vld_ff || rsp.ready;
   assign req.ready   = (state_ff == S_IDLE) && out_free;
   assign req_xfer    = req.valid && req.ready;
   assign table_full  = (count_ff == CW'(DEPTH));
   assign table_empty = (count_ff == '0);

   // shared key comparator on the registered store read data
   assign key_hit   = (mem_rd_key == key_ff);
   assign hit       = data_vld_ff && ((op_ff == OP_DUMP) || key_hit);
   assign stall     = hit && pend_vld_ff && !out_free;
   assign scan_done = !data_vld_ff && (rd_ptr_ff == count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer && (req_op != OP_INSERT) && !table_empty) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      data_vld_in   = data_vld_ff;
      pend_vld_in   = pend_vld_ff;
      pend_key_in   = pend_key_ff;
      pend_value_in = pend_value_ff;
      out_vld_in    = out_vld_ff && !rsp.ready;
      out_status_in = out_status_ff;
      out_key_in    = out_key_ff;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = wr_ptr_ff[AW-1:0];
      mem_wr_key    = mem_rd_key;
      mem_wr_value  = mem_rd_value;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = rd_ptr_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               op_in       = req_op;
               key_in      = req.key;
               rd_ptr_in   = '0;
               wr_ptr_in   = '0;
               data_vld_in = 1'b0;
               pend_vld_in = 1'b0;
               if (req_op == OP_INSERT) begin
                  out_vld_in   = 1'b1;
                  out_last_in  = 1'b1;
                  out_key_in   = '0;
                  out_value_in = '0;
                  if (table_full) begin
                     out_status_in = ST_FULL;
                  end else begin
                     out_status_in = ST_OK;
                     out_key_in    = req_key_ext[OUT_WIDTH-1:0];
                     out_value_in  = req_value_ext[OUT_WIDTH-1:0];
                     mem_wr_en     = 1'b1;
                     mem_wr_addr   = count_ff[AW-1:0];
                     mem_wr_key    = req.key;
                     mem_wr_value  = req.value;
                     count_in      = count_ff + CW'(1);
                  end
               end else if (table_empty) begin
                  out_vld_in    = 1'b1;
                  out_last_in   = 1'b1;
                  out_status_in = ST_EMPTY;
                  out_key_in    = '0;
                  out_value_in  = '0;
               end
            end
         end

         S_SCAN: begin
            if (!stall) begin
               // a match replaces the held one; the held one goes out
               if (hit) begin
                  pend_vld_in   = 1'b1;
                  pend_key_in   = mem_rd_key;
                  pend_value_in = mem_rd_value;
                  if (pend_vld_ff) begin
                     out_vld_in    = 1'b1;
                     out_status_in = ST_OK;
                     out_key_in    = pend_key_ext[OUT_WIDTH-1:0];
                     out_value_in  = pend_value_ext[OUT_WIDTH-1:0];
                     out_last_in   = 1'b0;
                  end
               end
               // remove keeps non-matching entries, packed toward slot zero
               if (data_vld_ff && (op_ff == OP_REMOVE) && !key_hit) begin
                  mem_wr_en = 1'b1;
                  wr_ptr_in = wr_ptr_ff + CW'(1);
               end
               // issue the next read
               if (rd_ptr_ff != count_ff) begin
                  mem_rd_en   = 1'b1;
                  rd_ptr_in   = rd_ptr_ff + CW'(1);
                  data_vld_in = 1'b1;
               end else begin
                  data_vld_in = 1'b0;
               end
            end
         end

         S_FLUSH: begin
            if (out_free) begin
               out_vld_in  = 1'b1;
               out_last_in = 1'b1;
               pend_vld_in = 1'b0;
               if (pend_vld_ff) begin
                  out_status_in = ST_OK;
                  out_key_in    = pend_key_ext[OUT_WIDTH-1:0];
                  out_value_in  = pend_value_ext[OUT_WIDTH-1:0];
               end else begin
                  out_status_in = ST_ABSENT;
                  out_key_in    = '0;
                  out_value_in  = '0;
               end
               if (op_ff == OP_REMOVE) begin
                  count_in = wr_ptr_ff;
               end
            end
         end

         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         data_vld_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         data_vld_ff <= data_vld_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      wr_ptr_ff     <= wr_ptr_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      pend_key_ff   <= pend_key_in;
      pend_value_ff <= pend_value_in;
      out_status_ff <= out_status_in;
      out_key_ff    <= out_key_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
   end

   // response channel
   assign rsp.valid       = out_vld_ff;
   assign rsp.status      = out_status_ff;
   assign rsp.entry_key   = out_key_ff;
   assign rsp.entry_value = out_value_ff;
   assign rsp.last        = out_last_ff;

endmodule

// File: design/multimap_key_value_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multimap_key_value_table: fixed-depth multimap of key/value pairs
// Usage:
//   req_chan carries one operation per transfer (opcode, key, value):
//   insert, find all, remove all matching, dump all. rsp_chan returns one or
//   more results (status, entry_key, entry_value, last); last marks the
//   final result of a request.
//   Insert, and any other operation on an empty table, answers in the cycle
//   after the request transfer and the block is ready again at once.
//   Find, remove and dump walk the n stored pairs through one key comparator
//   at one store read per cycle while the output is not stalled; the block
//   takes no new request until the final result is in the output register.
//   The response sits in an output register; a new request is taken while a
//   finished result waits, as long as it is taken in the same cycle.
//   When the receiver stalls, the walk pauses on the next match and resumes
//   when the output register drains; nothing is lost.
//   Reset clears the entry count and all handshake state; the pair store
//   itself is not cleared and only slots below the count are ever read.
// ----------------------------------------------------------------------------
module multimap_key_value_table
   import mkv_pkg::*;
#(
   parameter int DEPTH       = 32,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   mkv_req_if.sink     req_chan,
   mkv_rsp_if.source   rsp_chan
);

   localparam int AW = $clog2(DEPTH);

   logic                   mem_wr_en;
   logic [AW-1:0]          mem_wr_addr;
   logic [KEY_WIDTH-1:0]   mem_wr_key;
   logic [VALUE_WIDTH-1:0] mem_wr_value;
   logic                   mem_rd_en;
   logic [AW-1:0]          mem_rd_addr;
   logic [KEY_WIDTH-1:0]   mem_rd_key;
   logic [VALUE_WIDTH-1:0] mem_rd_value;

   // sequencer with the shared comparator and output register
   mkv_ctrl #(
      .DEPTH       (DEPTH),
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_mkv_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .rsp          (rsp_chan),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_key   (mem_wr_key),
      .mem_wr_value (mem_wr_value),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_key   (mem_rd_key),
      .mem_rd_value (mem_rd_value)
   );

   // pair store
   mkv_store #(
      .DEPTH       (DEPTH),
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_mkv_store (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_key   (mem_wr_key),
      .wr_value (mem_wr_value),
      .rd_en    (mem_rd_en),
      .rd_addr  (mem_rd_addr),
      .rd_key   (mem_rd_key),
      .rd_value (mem_rd_value)
   );

endmodule

// File: design/mkv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkv_checker: port-level checks of the multimap key/value table
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module mkv_checker
   import mkv_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [STATUS_WIDTH-1:0] rsp_status,
   input logic [OUT_WIDTH-1:0]    rsp_entry_key,
   input logic [OUT_WIDTH-1:0]    rsp_entry_value,
   input logic                    rsp_last
);

   // nothing is offered right after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_last)
         && $stable(rsp_entry_key) && $stable(rsp_entry_value))
      else $error("stalled response changed");

   // error statuses are single, final results with cleared fields
   a_status_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
         rsp_last && (rsp_entry_key == '0) && (rsp_entry_value == '0))
      else $error("error status not a lone final result");

   // no new request while earlier results of the current one are pending
   a_busy_mid_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request accepted before the final result");

endmodule

bind multimap_key_value_table mkv_checker u_mkv_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_entry_key   (rsp_chan.entry_key),
   .rsp_entry_value (rsp_chan.entry_value),
   .rsp_last        (rsp_chan.last)
);

// File: dv/multimap_key_value_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multimap_key_value_table_test: self-checking bench for the key/value table
// Drives insert, find, remove and dump requests over the request channel,
// predicts every result from a local copy of the table, and compares each
// response transfer field by field in order, under random stalls on both sides.
// ----------------------------------------------------------------------------
module multimap_key_value_table_test
   import mkv_pkg::*;
();

   localparam int DEPTH       = 32;
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      status_type      status;
      logic [31:0]     entry_key;
      logic [31:0]     entry_value;
      logic            last;
   } table_result_type;

   logic clock;
   logic reset;

   mkv_req_if #(.KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)) req_chan ();
   mkv_rsp_if rsp_chan ();

   multimap_key_value_table #(
      .DEPTH       (DEPTH),
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // local copy of the table, in insertion order
   logic [KEY_WIDTH-1:0]   stored_keys [DEPTH];
   logic [VALUE_WIDTH-1:0] stored_values [DEPTH];
   int                     stored_count;

   table_result_type       expected_results [$];
   logic [KEY_WIDTH-1:0]   key_pool [8];

   int send_idle_pct;
   int recv_idle_pct;
   int error_count;
   int cycle_count;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("multimap_key_value_table_test: errors");
         $finish;
      end
   end

   // receiver: random back-pressure
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // append one result to the expected queue
   function automatic void queue_result(table_result_type r);
      expected_results = {expected_results, r};
   endfunction

   // compute the results of one accepted request and update the table copy
   function automatic void predict_table_op(opcode_type op, logic [KEY_WIDTH-1:0] k,
                                            logic [VALUE_WIDTH-1:0] v);
      table_result_type r;
      int hits;
      int emitted;
      int kept;
      r = '{ST_OK, 32'd0, 32'd0, 1'b1};
      hits = 0;
      emitted = 0;
      kept = 0;
      if (op == OP_INSERT) begin
         if (stored_count >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            stored_keys[stored_count] = k;
            stored_values[stored_count] = v;
            stored_count++;
            r.entry_key = k;
            r.entry_value = v;
         end
         queue_result(r);
         return;
      end
      if (stored_count == 0) begin
         r.status = ST_EMPTY;
         queue_result(r);
         return;
      end
      if (op == OP_DUMP) begin
         for (int i = 0; i < stored_count; i++) begin
            r.entry_key = stored_keys[i];
            r.entry_value = stored_values[i];
            r.last = (i == stored_count - 1);
            queue_result(r);
         end
         return;
      end
      for (int i = 0; i < stored_count; i++)
         if (stored_keys[i] == k) hits++;
      if (hits == 0) begin
         r.status = ST_ABSENT;
         queue_result(r);
         return;
      end
      // emit matches in order; remove compacts the survivors
      for (int i = 0; i < stored_count; i++) begin
         if (stored_keys[i] == k) begin
            emitted++;
            r.entry_key = stored_keys[i];
            r.entry_value = stored_values[i];
            r.last = (emitted == hits);
            queue_result(r);
            if (op == OP_FIND) begin
               stored_keys[kept] = stored_keys[i];
               stored_values[kept] = stored_values[i];
               kept++;
            end
         end else begin
            stored_keys[kept] = stored_keys[i];
            stored_values[kept] = stored_values[i];
            kept++;
         end
      end
      stored_count = kept;
   endfunction

   // response checker
   always @(posedge clock) begin
      table_result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result transfer: status %0d key %h value %h last %0d",
                   rsp_chan.status, rsp_chan.entry_key, rsp_chan.entry_value,
                   rsp_chan.last);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_chan.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
               error_count++;
            end
            if (rsp_chan.entry_key !== want.entry_key) begin
               $error("entry_key: expected %h, got %h", want.entry_key, rsp_chan.entry_key);
               error_count++;
            end
            if (rsp_chan.entry_value !== want.entry_value) begin
               $error("entry_value: expected %h, got %h", want.entry_value,
                      rsp_chan.entry_value);
               error_count++;
            end
            if (rsp_chan.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_chan.last);
               error_count++;
            end
         end
      end
   end

   // one request transfer; called and returns at a falling edge
   task automatic send_request(opcode_type op, logic [KEY_WIDTH-1:0] k,
                               logic [VALUE_WIDTH-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         req_chan.key <= $urandom;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= op;
      req_chan.key <= k;
      req_chan.value <= v;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predict_table_op(op, k, v);
      @(negedge clock);
   endtask

   // hold off the sender until every outstanding result has arrived
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // mostly keys from a small pool so that finds and removes hit
   function automatic logic [KEY_WIDTH-1:0] pick_key();
      if ($urandom_range(99) < 80) return key_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   task automatic new_key_pool();
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
      key_pool[0] = '0;
      key_pool[7] = '1;
   endtask

   // find, remove and dump on an empty table
   task automatic test_empty_table();
      send_request(OP_FIND, 32'h0000_0005, 32'h0);
      send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_DUMP, 32'h0, 32'h0);
   endtask

   // field extremes, repeated keys, find/remove hits and misses, compaction
   task automatic test_directed_ops();
      send_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'h0000_0005, 32'h0000_0001);
      send_request(OP_INSERT, 32'h0000_0005, 32'h0000_0002);
      send_request(OP_INSERT, 32'h0000_0000, 32'hA5A5_5A5A);
      send_request(OP_FIND, 32'h0000_0005, 32'h0);
      send_request(OP_FIND, 32'h0000_0007, 32'h0);
      send_request(OP_DUMP, 32'h0, 32'hFFFF_FFFF);
      send_request(OP_REMOVE, 32'h0000_0005, 32'h0);
      send_request(OP_REMOVE, 32'h0000_0005, 32'h0);
      send_request(OP_DUMP, 32'h0, 32'h0);
      send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_REMOVE, 32'h0000_0000, 32'h0);
      send_request(OP_FIND, 32'h0000_0000, 32'h0);
   endtask

   // fill to capacity, overflow, then remove every pool key
   task automatic test_fill_and_drain();
      while (stored_count < DEPTH)
         send_request(OP_INSERT, key_pool[$urandom_range(7)], $urandom);
      send_request(OP_INSERT, $urandom, $urandom);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_DUMP, $urandom, $urandom);
      send_request(OP_FIND, key_pool[$urandom_range(7)], $urandom);
      for (int i = 0; i < 8; i++) send_request(OP_REMOVE, key_pool[i], $urandom);
      send_request(OP_DUMP, $urandom, $urandom);
   endtask

   // random mix, biased toward inserts so the table fill wanders
   task automatic test_random_ops(int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 45) send_request(OP_INSERT, pick_key(), $urandom);
         else if (pick < 65) send_request(OP_FIND, pick_key(), $urandom);
         else if (pick < 88) send_request(OP_REMOVE, pick_key(), $urandom);
         else send_request(OP_DUMP, $urandom, $urandom);
      end
   endtask

   // main sequence
   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.opcode = OP_INSERT;
      req_chan.key = '0;
      req_chan.value = '0;
      rsp_chan.ready = 1'b0;
      stored_count = 0;
      error_count = 0;
      cycle_count = 0;
      set_idling(19, 84);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_table();
      test_directed_ops();

      // sender idles little, receiver stalls heavily
      new_key_pool();
      test_random_ops(80);
      test_fill_and_drain();
      wait_for_results();

      // sender idles heavily, receiver stalls little
      set_idling(84, 19);
      new_key_pool();
      test_random_ops(80);
      test_fill_and_drain();
      wait_for_results();

      // back-to-back in both directions
      set_idling(0, 0);
      new_key_pool();
      test_random_ops(80);
      test_fill_and_drain();

      wait_for_results();
      repeat (2 * DEPTH) @(posedge clock);
      if (error_count == 0) begin
         $display("multimap_key_value_table_test: clean");
      end else begin
         $display("multimap_key_value_table_test: errors");
      end
      $finish;
   end

endmodule
